// ===== rtl/b4k_pkg.sv =====
// Shared types and constants for the base4k stream decoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package b4k_pkg;

  localparam logic [15:0] DATA_START = 16'h5000;
  localparam logic [15:0] DATA_END   = 16'hA000;
  localparam logic [7:0]  FLAG_HIGH  = 8'h40;

  // One decoded unit as handed from the front to the back.
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       two;
    logic       byte_valid;
    logic       message_end;
    logic       decode_error;
  } b4k_entry_t;

endpackage

// ===== rtl/b4k_front.sv =====
// Front end: classifies each code unit, keeps the message state and builds a queue entry.
// Depends on b4k_pkg.
module b4k_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [15:0]       code_unit,
  input  logic              last_unit,
  output logic              push,
  output b4k_pkg::b4k_entry_t entry
);

  logic       odd_r, odd_nxt;
  logic [3:0] held_r, held_nxt;
  logic       failed_r, failed_nxt;
  logic       is_data, is_flag, bad;
  logic [15:0] v_data;

  assign is_data = (code_unit >= b4k_pkg::DATA_START) && (code_unit < b4k_pkg::DATA_END);
  assign is_flag = (code_unit[15:8] == b4k_pkg::FLAG_HIGH);
  assign bad     = !is_data && !(is_flag && last_unit);
  assign v_data  = code_unit - b4k_pkg::DATA_START;

  always_comb begin
    push       = 1'b0;
    entry      = '0;
    odd_nxt    = odd_r;
    held_nxt   = held_r;
    failed_nxt = failed_r;
    if (failed_r) begin
      push               = last_unit;
      entry.message_end  = 1'b1;
      entry.decode_error = 1'b1;
    end else if (bad) begin
      push               = 1'b1;
      entry.message_end  = last_unit;
      entry.decode_error = 1'b1;
      failed_nxt         = 1'b1;
    end else if (is_data) begin
      push             = 1'b1;
      entry.byte_valid = 1'b1;
      entry.message_end = last_unit;
      held_nxt         = v_data[3:0];
      odd_nxt          = !odd_r;
      if (!odd_r) begin
        entry.byte0 = v_data[11:4];
      end else begin
        entry.byte0 = {held_r, v_data[11:8]};
        entry.byte1 = v_data[7:0];
        entry.two   = 1'b1;
      end
    end else begin
      push              = 1'b1;
      entry.byte_valid  = 1'b1;
      entry.message_end = 1'b1;
      entry.byte0       = odd_r ? {held_r, code_unit[3:0]} : code_unit[7:0];
    end
    if (last_unit) begin
      odd_nxt    = 1'b0;
      held_nxt   = '0;
      failed_nxt = 1'b0;
    end
    push = push && accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      odd_r    <= 1'b0;
      held_r   <= '0;
      failed_r <= 1'b0;
    end else if (accept) begin
      odd_r    <= odd_nxt;
      held_r   <= held_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

// ===== rtl/b4k_queue.sv =====
// Small register queue that carries decoded entries from the front to the back.
// Depends on b4k_pkg.
module b4k_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  b4k_pkg::b4k_entry_t push_entry,
  input  logic                pop,
  output b4k_pkg::b4k_entry_t head,
  output logic                empty,
  output logic                full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  b4k_pkg::b4k_entry_t mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == FULL_CNT);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = do_push ? ((wr_r == LAST_PTR) ? '0 : wr_r + PW'(1)) : wr_r;
    rd_nxt  = do_pop  ? ((rd_r == LAST_PTR) ? '0 : rd_r + PW'(1)) : rd_r;
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/b4k_back.sv =====
// Back end: turns queue entries into one or two result beats held in an output register.
// Depends on b4k_pkg.
module b4k_back (
  input  logic                clk,
  input  logic                rst_n,
  input  b4k_pkg::b4k_entry_t head,
  input  logic                empty,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tlast,
  output logic [2:0]          out_tuser
);

  logic       valid_r, valid_nxt;
  logic       second_r, second_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic [2:0] user_r, user_nxt;
  logic       load, first_of_two;

  assign load         = !valid_r || out_tready;
  assign first_of_two = head.two && !second_r;

  always_comb begin
    valid_nxt  = valid_r;
    second_nxt = second_r;
    byte_nxt   = byte_r;
    last_nxt   = last_r;
    user_nxt   = user_r;
    pop        = 1'b0;
    if (load) begin
      valid_nxt = !empty;
      if (!empty) begin
        byte_nxt = second_r ? head.byte1 : head.byte0;
        if (first_of_two) begin
          last_nxt   = 1'b0;
          user_nxt   = {head.decode_error, 1'b0, head.byte_valid};
          second_nxt = 1'b1;
        end else begin
          last_nxt   = head.message_end;
          user_nxt   = {head.decode_error, 1'b1, head.byte_valid};
          second_nxt = 1'b0;
          pop        = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      second_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      second_r <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    user_r <= user_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = byte_r;
  assign out_tlast  = last_r;
  assign out_tuser  = user_r;

endmodule

// ===== rtl/base4k_stream_decoder.sv =====
// Top level of the base4k stream decoder: front end, entry queue and back end.
// Depends on b4k_pkg, b4k_front, b4k_queue and b4k_back.
//
// Each 16-bit code unit beat is classified in the cycle it is accepted and
// yields zero, one or two result beats, which the back end sends from its
// output register, one per cycle while out_tready is high. An odd-position
// data unit therefore yields two result beats and every other unit at most
// one, so the output channel is the limit. Input is taken every cycle while
// the entry queue (QUEUE_DEPTH entries) has room.
module base4k_stream_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // code_unit
  input  logic        in_tlast,   // last_unit
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte
  output logic        out_tlast,  // message_end
  output logic [2:0]  out_tuser   // byte_valid, run_last, decode_error
);

  b4k_pkg::b4k_entry_t push_entry, head;
  logic push, pop, empty, full, accept;

  assign in_tready = !full;
  assign accept    = in_tvalid && !full;

  b4k_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .code_unit (in_tdata),
    .last_unit (in_tlast),
    .push      (push),
    .entry     (push_entry)
  );

  b4k_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  b4k_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== verif/tb_base4k_stream_decoder.sv =====
// Self-checking testbench for base4k_stream_decoder: directed and random code unit
// streams, with random idling on both channels and one long receiver hold-off.
// Depends on b4k_pkg and the base4k_stream_decoder RTL.
module tb_base4k_stream_decoder;

  localparam int USER_VALID    = 0;
  localparam int USER_RUN_LAST = 1;
  localparam int USER_ERROR    = 2;
  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 120;
  localparam int TAIL_CYCLES   = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       run_last;
    logic       message_end;
    logic       decode_error;
  } b4k_beat_t;

  class b4k_byte_scoreboard;
    bit        odd_pos;
    bit [3:0]  held_nib;
    bit        msg_failed;
    b4k_beat_t due_bytes[$];
    int        errors;

    function void queue_beat(bit [7:0] data, bit valid, bit rlast, bit mend, bit err);
      b4k_beat_t b;
      b.data         = data;
      b.byte_valid   = valid;
      b.run_last     = rlast;
      b.message_end  = mend;
      b.decode_error = err;
      due_bytes.push_back(b);
    endfunction

    // Works out the beats that one accepted code unit should produce.
    function void decode_unit(logic [15:0] code, logic last);
      bit [15:0] v;
      bit        is_data;
      bit        is_flag;
      is_data = (code >= b4k_pkg::DATA_START) && (code < b4k_pkg::DATA_END);
      is_flag = (code[15:8] == b4k_pkg::FLAG_HIGH);
      if (msg_failed) begin
        if (last)
          queue_beat(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
      end else if (!is_data && !(is_flag && last)) begin
        queue_beat(8'h00, 1'b0, 1'b1, last, 1'b1);
        msg_failed = 1'b1;
      end else if (is_data) begin
        v = code - b4k_pkg::DATA_START;
        if (!odd_pos) begin
          queue_beat(v[11:4], 1'b1, 1'b1, last, 1'b0);
          odd_pos = 1'b1;
        end else begin
          queue_beat({held_nib, v[11:8]}, 1'b1, 1'b0, 1'b0, 1'b0);
          queue_beat(v[7:0], 1'b1, 1'b1, last, 1'b0);
          odd_pos = 1'b0;
        end
        held_nib = v[3:0];
      end else begin
        queue_beat(odd_pos ? {held_nib, code[3:0]} : code[7:0], 1'b1, 1'b1, 1'b1, 1'b0);
      end
      if (last) begin
        odd_pos    = 1'b0;
        held_nib   = 4'h0;
        msg_failed = 1'b0;
      end
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_beat(logic [7:0] data, logic [2:0] user, logic last);
      b4k_beat_t want;
      if (due_bytes.size() == 0) begin
        report($sformatf("unexpected beat data=%0h user=%b last=%b", data, user, last));
      end else begin
        want = due_bytes.pop_front();
        if (data !== want.data)
          report($sformatf("out_byte got %0h want %0h", data, want.data));
        if (user[USER_VALID] !== want.byte_valid)
          report($sformatf("byte_valid got %b want %b", user[USER_VALID], want.byte_valid));
        if (user[USER_RUN_LAST] !== want.run_last)
          report($sformatf("run_last got %b want %b", user[USER_RUN_LAST], want.run_last));
        if (last !== want.message_end)
          report($sformatf("message_end got %b want %b", last, want.message_end));
        if (user[USER_ERROR] !== want.decode_error)
          report($sformatf("decode_error got %b want %b", user[USER_ERROR],
                           want.decode_error));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic [2:0]  out_tuser;

  b4k_byte_scoreboard sb = new();
  bit tx_gaps  = 1'b1;
  bit rx_gaps  = 1'b1;
  bit hold_req = 1'b0;
  int units_sent;
  int quiet_cycles;

  base4k_stream_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Both channels are observed here so that a unit is always predicted before
  // any beat that it could cause is checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.decode_unit(in_tdata, in_tlast);
      if (out_tvalid && out_tready)
        sb.check_beat(out_tdata, out_tuser, out_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_unit(input logic [15:0] code, input logic last);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    in_tlast  <= last;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    units_sent++;
    @(negedge clk);
  endtask

  function automatic logic [15:0] data_unit();
    return b4k_pkg::DATA_START + 16'($urandom_range(0, 16'h4FFF));
  endfunction

  function automatic logic [15:0] bad_unit();
    case ($urandom_range(0, 5))
      0:       return 16'h4FFF;
      1:       return b4k_pkg::DATA_END;
      2:       return {b4k_pkg::FLAG_HIGH, 8'h00} + 16'h0100;
      3:       return {b4k_pkg::FLAG_HIGH, 8'($urandom)};
      4:       return {b4k_pkg::FLAG_HIGH, 8'h00} - 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_message(input bit broken);
    int len;
    int bad_at;
    bit flag_end;
    logic last;
    logic [15:0] code;
    len      = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
    flag_end = $urandom_range(0, 1);
    bad_at   = broken ? $urandom_range(0, len - 1) : -1;
    for (int i = 0; i < len; i++) begin
      last = (i == len - 1);
      if (i == bad_at)
        code = bad_unit();
      else if (last && flag_end)
        code = {b4k_pkg::FLAG_HIGH, 8'($urandom)};
      else
        code = data_unit();
      send_unit(code, last);
    end
  endtask

  initial begin
    int pick;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Field extremes, both positions, flag endings and failed messages.
    send_unit(16'h5000, 1'b0);
    send_unit(16'h9FFF, 1'b0);
    send_unit(16'h5ABC, 1'b0);
    send_unit(16'h40FF, 1'b1);
    send_unit(16'h9FFF, 1'b1);
    send_unit(16'h5123, 1'b0);
    send_unit(16'h9FFF, 1'b1);
    send_unit(16'h4000, 1'b1);
    send_unit(16'h40FF, 1'b1);
    send_unit(16'h9FFF, 1'b0);
    send_unit(16'h40A5, 1'b1);
    send_unit(16'h4012, 1'b0);
    send_unit(16'h5000, 1'b0);
    send_unit(16'h4000, 1'b1);
    send_unit(16'h0000, 1'b1);
    send_unit(16'hFFFF, 1'b0);
    send_unit(16'h4100, 1'b1);
    send_unit(16'h3FFF, 1'b1);
    send_unit(16'h4FFF, 1'b1);
    send_unit(16'h5000, 1'b0);
    send_unit(16'hA000, 1'b1);
    send_unit(16'h5555, 1'b0);
    send_unit(16'hFFFF, 1'b0);
    send_unit(16'h0000, 1'b0);
    send_unit(16'h9FFF, 1'b1);

    while (units_sent < 775) begin
      if (units_sent >= 620) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end
      if (units_sent >= 250 && units_sent < 260)
        hold_req = 1'b1;
      pick = $urandom_range(0, 9);
      if (pick < 7)
        send_message(1'b0);
      else if (pick < 9)
        send_message(1'b1);
      else
        repeat ($urandom_range(1, 4)) send_unit(16'($urandom), $urandom_range(0, 7) == 0);
    end
    in_tvalid <= 1'b0;

    while (sb.due_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/b4k_pkg.sv
rtl/b4k_front.sv
rtl/b4k_queue.sv
rtl/b4k_back.sv
rtl/base4k_stream_decoder.sv
verif/tb_base4k_stream_decoder.sv
